>>> src/cvse_pkg.sv
`default_nettype none
package cvse_pkg;

    localparam int MAX_CORES = 4;
    localparam int CORE_IW   = (MAX_CORES > 1) ? $clog2(MAX_CORES) : 1;

    localparam int QDEPTH = 4;
    localparam int QAW    = $clog2(QDEPTH);
    localparam int QCW    = $clog2(QDEPTH + 1);

    localparam logic       CFG_REV = 1'b0;
    localparam logic       CFG_ACT = 1'b1;

    localparam logic [1:0] REV_NONE  = 2'd0;
    localparam logic [1:0] REV_FIRST = 2'd1;
    localparam logic [1:0] REV_RESET = REV_NONE;
    localparam logic [2:0] ACT_RESET = 3'd4;

    localparam logic [21:0] V1_OFFSET  = 22'd62100;
    localparam logic [26:0] V1_MUL     = 27'd23;
    localparam logic [7:0]  B1_TRUNC   = 8'hF8;
    localparam logic [21:0] B1_MIN     = 22'd350000;
    localparam logic [21:0] B1_MAX     = 22'd650000;
    localparam logic [21:0] B2_MIN     = 22'd700000;
    localparam logic [21:0] B2_MAX     = 22'd1400000;
    localparam logic [21:0] B3_BASE    = 22'd1400000;
    localparam logic [21:0] B3_SET_MIN = 22'd1500000;
    localparam logic [21:0] B3_MAX     = 22'd3300000;
    localparam logic [21:0] BOOT_UV    = 22'd1200000;
    localparam logic [21:0] INIT_UV    = 22'd950000;

    // reciprocals for exact floor division: ceil(2^k / d)
    localparam logic [27:0] RCP_25   = 28'd171798692;
    localparam int          SH_25    = 32;
    localparam logic [22:0] RCP_1250 = 23'd6871948;
    localparam int          SH_1250  = 33;
    localparam logic [21:0] RCP_6250 = 22'd2748780;
    localparam int          SH_6250  = 34;

    localparam logic [1:0] BAND_1 = 2'd1;
    localparam logic [1:0] BAND_2 = 2'd2;
    localparam logic [1:0] BAND_3 = 2'd3;

    typedef enum logic [1:0] {
        OUT_PROGRAMMED,
        OUT_BOOT_KEPT,
        OUT_REV_FAULT,
        OUT_RANGE
    } t_outcome;

    typedef struct packed {
        logic [2:0]  core;
        logic        fail;
        t_outcome    fail_outcome;
        logic        scale;
        logic [26:0] val;
        logic [21:0] diff;
    } t_q_item;

endpackage
`default_nettype wire

>>> src/cvse_front.sv
`default_nettype none
module cvse_front (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_cfg_we,
    input  wire logic             i_cfg_idx,
    input  wire logic [2:0]       i_cfg_data,
    input  wire logic             i_valid,
    output logic                  o_ready,
    input  wire logic [2:0]       i_core,
    input  wire logic [21:0]      i_vmin,
    input  wire logic [21:0]      i_vmax,
    input  wire logic             i_full,
    output logic                  o_push,
    output cvse_pkg::t_q_item     o_item
);
    import cvse_pkg::*;

    logic [1:0]         r_rev;
    logic [2:0]         r_act;
    logic [21:0]        r_prev [MAX_CORES];
    logic [CORE_IW-1:0] idx;
    logic               tracked;
    logic               accept;
    logic [21:0]        prev;
    logic [21:0]        sub;

    assign o_ready = !i_full;
    assign accept  = i_valid && o_ready;
    assign o_push  = accept;
    assign idx     = CORE_IW'(i_core);
    assign tracked = (i_core < r_act) && (32'(i_core) < 32'(MAX_CORES));
    assign prev    = r_prev[idx];
    assign sub     = i_vmin - V1_OFFSET;

    always_comb begin
        o_item              = '0;
        o_item.core         = i_core;
        o_item.fail_outcome = OUT_PROGRAMMED;
        o_item.diff         = (tracked && (i_vmin > prev)) ? (i_vmin - prev) : 22'd0;
        case (r_rev)
            REV_NONE: begin
                o_item.fail = 1'b1;
                if ((i_vmin <= BOOT_UV) && (i_vmax >= BOOT_UV)) begin
                    o_item.fail_outcome = OUT_BOOT_KEPT;
                end else begin
                    o_item.fail_outcome = OUT_REV_FAULT;
                end
            end
            REV_FIRST: begin
                if (i_vmin < V1_OFFSET) begin
                    o_item.fail         = 1'b1;
                    o_item.fail_outcome = OUT_RANGE;
                end else begin
                    o_item.scale = 1'b1;
                    o_item.val   = 27'(sub) * V1_MUL;
                end
            end
            default: begin
                o_item.val = 27'(i_vmin);
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rev <= REV_RESET;
            r_act <= ACT_RESET;
            for (int i = 0; i < MAX_CORES; i++) begin
                r_prev[i] <= INIT_UV;
            end
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_REV: r_rev <= i_cfg_data[1:0];
                    CFG_ACT: r_act <= i_cfg_data;
                    default: ;
                endcase
            end
            if (accept && tracked) begin
                r_prev[idx] <= i_vmin;
            end
        end
    end

    a_track_update: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && tracked) |=> (r_prev[$past(idx)] == $past(i_vmin)))
        else $error("tracked entry not updated");

endmodule
`default_nettype wire

>>> src/cvse_queue.sv
`default_nettype none
module cvse_queue (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_push,
    input  wire cvse_pkg::t_q_item i_item,
    output logic                   o_full,
    input  wire logic              i_pop,
    output logic                   o_valid,
    output cvse_pkg::t_q_item      o_item
);
    import cvse_pkg::*;

    t_q_item        r_mem [QDEPTH];
    logic [QAW-1:0] r_wr;
    logic [QAW-1:0] r_rd;
    logic [QCW-1:0] r_count;

    assign o_full  = (r_count == QCW'(QDEPTH));
    assign o_valid = (r_count != '0);
    assign o_item  = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + QAW'(1);
            end
            if (i_pop) begin
                r_rd <= r_rd + QAW'(1);
            end
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + QCW'(1);
                2'b01:   r_count <= r_count - QCW'(1);
                default: r_count <= r_count;
            endcase
        end
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= QCW'(QDEPTH))
        else $error("queue count over depth");

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> !o_full)
        else $error("push into full queue");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> o_valid)
        else $error("pop from empty queue");

endmodule
`default_nettype wire

>>> src/cvse_back.sv
`default_nettype none
module cvse_back (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_q_valid,
    input  wire cvse_pkg::t_q_item i_q_item,
    output logic                   o_pop,
    output logic                   o_valid,
    input  wire logic              i_ready,
    output cvse_pkg::t_outcome     o_outcome,
    output logic                   o_pv,
    output logic [2:0]             o_core,
    output logic [7:0]             o_code,
    output logic [11:0]            o_delay
);
    import cvse_pkg::*;

    // stage a: scaled voltage and settle delay
    logic        r_a_valid;
    logic [2:0]  r_a_core;
    logic        r_a_fail;
    t_outcome    r_a_fail_outcome;
    logic [21:0] r_a_v;
    logic [11:0] r_a_delay;

    // output stage
    logic        r_o_valid;
    t_outcome    r_o_outcome;
    logic        r_o_pv;
    logic [2:0]  r_o_core;
    logic [7:0]  r_o_code;
    logic [11:0] r_o_delay;

    logic        en_o;
    logic        en_a;
    logic [54:0] scale_prod;
    logic [44:0] delay_prod;
    logic [21:0] n_a_v;
    logic [11:0] n_a_delay;

    t_outcome    n_o_outcome;
    logic        n_o_pv;
    logic [7:0]  n_o_code;
    logic [11:0] n_o_delay;

    assign en_o  = !r_o_valid || i_ready;
    assign en_a  = !r_a_valid || en_o;
    assign o_pop = i_q_valid && en_a;

    always_comb begin
        scale_prod = 55'(i_q_item.val) * 55'(RCP_25);
        delay_prod = 45'(i_q_item.diff) * 45'(RCP_1250);
        n_a_delay  = delay_prod[SH_1250 +: 12];
        if (i_q_item.scale) begin
            n_a_v = scale_prod[SH_25 +: 22];
        end else begin
            n_a_v = i_q_item.val[21:0];
        end
    end

    always_comb begin
        logic [21:0] vc;
        logic [21:0] base;
        logic [1:0]  band;
        logic [43:0] lvl_prod;
        logic [9:0]  q;
        logic [7:0]  lvl1;
        logic [5:0]  level;
        vc = r_a_v;
        if ((r_a_v > B1_MAX) && (r_a_v < B2_MIN)) begin
            vc = B1_MAX;
        end else if ((r_a_v > B2_MAX) && (r_a_v < B3_SET_MIN)) begin
            vc = B2_MAX;
        end
        if (vc < B2_MIN) begin
            base = B1_MIN;
            band = BAND_1;
        end else if (vc < B3_SET_MIN) begin
            base = B2_MIN;
            band = BAND_2;
        end else begin
            base = B3_BASE;
            band = BAND_3;
        end
        // one divide by 6250; band 2 and 3 steps are 2x and 8x that
        lvl_prod = 44'(vc - base) * 44'(RCP_6250);
        q        = lvl_prod[SH_6250 +: 10];
        lvl1     = q[7:0] & B1_TRUNC;
        case (band)
            BAND_1:  level = lvl1[5:0];
            BAND_2:  level = q[6:1];
            default: level = q[8:3];
        endcase

        n_o_outcome = OUT_PROGRAMMED;
        n_o_pv      = 1'b0;
        n_o_code    = 8'd0;
        n_o_delay   = 12'd0;
        if (r_a_fail) begin
            n_o_outcome = r_a_fail_outcome;
        end else if ((r_a_v < B1_MIN) || (r_a_v > B3_MAX)) begin
            n_o_outcome = OUT_RANGE;
        end else begin
            n_o_pv    = 1'b1;
            n_o_code  = {band, level};
            n_o_delay = r_a_delay;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
            r_o_valid <= 1'b0;
        end else begin
            if (en_a) begin
                r_a_valid <= i_q_valid;
            end
            if (en_o) begin
                r_o_valid <= r_a_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en_a) begin
            r_a_core         <= i_q_item.core;
            r_a_fail         <= i_q_item.fail;
            r_a_fail_outcome <= i_q_item.fail_outcome;
            r_a_v            <= n_a_v;
            r_a_delay        <= n_a_delay;
        end
        if (en_o) begin
            r_o_outcome <= n_o_outcome;
            r_o_pv      <= n_o_pv;
            r_o_core    <= r_a_core;
            r_o_code    <= n_o_code;
            r_o_delay   <= n_o_delay;
        end
    end

    assign o_valid   = r_o_valid;
    assign o_outcome = r_o_outcome;
    assign o_pv      = r_o_pv;
    assign o_core    = r_o_core;
    assign o_code    = r_o_code;
    assign o_delay   = r_o_delay;

    a_pv_outcome: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_o_valid && r_o_pv) |-> (r_o_outcome == OUT_PROGRAMMED))
        else $error("programmed flag without programmed outcome");

    a_stage_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_a_valid && r_o_valid && !i_ready) |=> r_a_valid)
        else $error("stage a item dropped under stall");

endmodule
`default_nettype wire

>>> src/core_voltage_setpoint_encoder_core.sv
`default_nettype none
// channel   | direction | handshake                     | payload
// ----------+-----------+-------------------------------+---------------------------------
// s_axis    | in        | s_axis_tvalid / s_axis_tready | tdata: core, min uv, max uv
// m_axis    | out       | m_axis_tvalid / m_axis_tready | tdata: core, code, delay; tuser
// cfg       | in        | i_cfg_we                      | i_cfg_idx, i_cfg_data
//
// one item per cycle unless m_axis_tready stalls; items pass queue, stage a, output stage
// front tracks per-core state and classifies, back scales, divides and encodes
// a four-entry queue between them absorbs output stalls before input ready drops
// synchronous reset loads 950000 uv into every tracked core and the config defaults
module core_voltage_setpoint_encoder_core (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire logic        i_cfg_idx,
    input  wire logic [2:0]  i_cfg_data,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [47:0] s_axis_tdata,  // core_number, request_min_uv, request_max_uv
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [23:0]      m_axis_tdata,  // target_core, supply_code, settle_delay_us
    output logic [2:0]       m_axis_tuser   // outcome, program_valid
);
    import cvse_pkg::*;

    logic     push;
    logic     full;
    logic     pop;
    logic     q_valid;
    t_q_item  push_item;
    t_q_item  pop_item;
    t_outcome outcome;
    logic     pv;
    logic [2:0]  core;
    logic [7:0]  code;
    logic [11:0] delay;

    cvse_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_valid    (s_axis_tvalid),
        .o_ready    (s_axis_tready),
        .i_core     (s_axis_tdata[2:0]),
        .i_vmin     (s_axis_tdata[24:3]),
        .i_vmax     (s_axis_tdata[46:25]),
        .i_full     (full),
        .o_push     (push),
        .o_item     (push_item)
    );

    cvse_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_item  (push_item),
        .o_full  (full),
        .i_pop   (pop),
        .o_valid (q_valid),
        .o_item  (pop_item)
    );

    cvse_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (q_valid),
        .i_q_item  (pop_item),
        .o_pop     (pop),
        .o_valid   (m_axis_tvalid),
        .i_ready   (m_axis_tready),
        .o_outcome (outcome),
        .o_pv      (pv),
        .o_core    (core),
        .o_code    (code),
        .o_delay   (delay)
    );

    assign m_axis_tdata = {1'b0, delay, code, core};
    assign m_axis_tuser = {pv, outcome};

endmodule
`default_nettype wire
